// ===== rtl/ctc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants of the C token classifier
// Token record, token class codes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int KW_IDX_W = 6;
  localparam int WLEN_W   = 6;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  localparam logic [2:0] CLS_KEYWORD = 3'd0;
  localparam logic [2:0] CLS_IDENT   = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_REL_OP  = 3'd3;
  localparam logic [2:0] CLS_ARI_OP  = 3'd4;
  localparam logic [2:0] CLS_PUNCT   = 3'd5;

  typedef struct packed {
    logic [2:0]          token_class;
    logic [KW_IDX_W-1:0] keyword_index;
    logic [7:0]          first_char;
    logic [7:0]          second_char;
    logic                run_last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "_" || c == "*";
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7e && !is_letter(c) && !is_digit(c);
  endfunction

  // keyword text, right aligned: last character in the low byte
  function automatic logic [127:0] kw_row(input logic [KW_IDX_W-1:0] k);
    logic [127:0] r;
    r = '0;
    case (k)
      6'd0:  r = 128'("main");
      6'd1:  r = 128'("auto");
      6'd2:  r = 128'("double");
      6'd3:  r = 128'("int");
      6'd4:  r = 128'("struct");
      6'd5:  r = 128'("break");
      6'd6:  r = 128'("else");
      6'd7:  r = 128'("long int");
      6'd8:  r = 128'("long double");
      6'd9:  r = 128'("switch");
      6'd10: r = 128'("case");
      6'd11: r = 128'("enum");
      6'd12: r = 128'("register");
      6'd13: r = 128'("typedef");
      6'd14: r = 128'("char");
      6'd15: r = 128'("extern");
      6'd16: r = 128'("return");
      6'd17: r = 128'("union");
      6'd18: r = 128'("const");
      6'd19: r = 128'("float");
      6'd20: r = 128'("short int");
      6'd21: r = 128'("unsigned");
      6'd22: r = 128'("continue");
      6'd23: r = 128'("for");
      6'd24: r = 128'("signed");
      6'd25: r = 128'("void");
      6'd26: r = 128'("default");
      6'd27: r = 128'("goto");
      6'd28: r = 128'("sizeof");
      6'd29: r = 128'("volatile");
      6'd30: r = 128'("do");
      6'd31: r = 128'("if");
      6'd32: r = 128'("static");
      6'd33: r = 128'("while");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] kw_len(input logic [KW_IDX_W-1:0] k);
    logic [4:0] n;
    n = 5'd0;
    case (k)
      6'd0, 6'd1, 6'd6, 6'd10, 6'd11, 6'd14, 6'd25, 6'd27: n = 5'd4;
      6'd2, 6'd4, 6'd9, 6'd15, 6'd16, 6'd24, 6'd28, 6'd32: n = 5'd6;
      6'd3, 6'd23:                                          n = 5'd3;
      6'd5, 6'd17, 6'd18, 6'd19, 6'd33:                     n = 5'd5;
      6'd7, 6'd12, 6'd21, 6'd22, 6'd29:                     n = 5'd8;
      6'd8:                                                 n = 5'd11;
      6'd13, 6'd26:                                         n = 5'd7;
      6'd20:                                                n = 5'd9;
      6'd30, 6'd31:                                         n = 5'd2;
      default:                                              n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                         input logic [3:0] p);
    logic [127:0] r;
    logic [4:0]   len;
    logic [4:0]   pos;
    logic [7:0]   ch;
    r   = kw_row(k);
    len = kw_len(k);
    pos = len - 5'd1 - {1'b0, p};
    ch  = 8'd0;
    if ({1'b0, p} < len) begin
      ch = r[{pos[3:0], 3'b000} +: 8];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ctc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_front: byte scanner
// Classifies each byte, tracks the pending token and the keyword match mask,
// and hands zero, one or two finished tokens per byte to the token queue.
// ----------------------------------------------------------------------------
module ctc_front #(
  parameter int KEYWORD_COUNT   = 34,
  parameter int MAX_WORD_LENGTH = 32,
  parameter int KEYWORD_CHARS   = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_text,
  output ctc_pkg::tok_pair_t       toks
);
  import ctc_pkg::*;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_WORD = 3'd1;
  localparam logic [2:0] MODE_NUM  = 3'd2;
  localparam logic [2:0] MODE_REL  = 3'd3;
  localparam logic [2:0] MODE_ARI  = 3'd4;

  localparam logic [WLEN_W-1:0] MAX_LEN  = WLEN_W'(MAX_WORD_LENGTH);
  localparam logic [WLEN_W-1:0] KW_CHARS = WLEN_W'(KEYWORD_CHARS);

  logic [2:0]               mode_r, mode_nxt;
  logic [7:0]               held_r, held_nxt;
  logic [WLEN_W-1:0]        wlen_r, wlen_nxt;
  logic [KEYWORD_COUNT-1:0] mask_r, mask_nxt;
  logic [KEYWORD_COUNT-1:0] ext_mask, start_mask;

  function automatic tok_t word_tok(input logic [KEYWORD_COUNT-1:0] m,
                                    input logic [WLEN_W-1:0] len);
    tok_t       t;
    logic [4:0] kl;
    t             = '0;
    t.token_class = CLS_IDENT;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      kl = kw_len(KW_IDX_W'(k));
      if (m[k] && kl != 5'd0 && {1'b0, kl} <= KW_CHARS && {1'b0, kl} == len) begin
        t.token_class   = CLS_KEYWORD;
        t.keyword_index = KW_IDX_W'(k);
      end
    end
    return t;
  endfunction

  function automatic tok_t op_tok(input logic [2:0] cls, input logic [7:0] c1,
                                  input logic [7:0] c2);
    tok_t t;
    t             = '0;
    t.token_class = cls;
    t.first_char  = c1;
    t.second_char = c2;
    return t;
  endfunction

  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      ext_mask[k]   = mask_r[k] && (wlen_r < KW_CHARS) &&
                      (kw_char(KW_IDX_W'(k), wlen_r[3:0]) == text_byte);
      start_mask[k] = (kw_char(KW_IDX_W'(k), 4'd0) == text_byte);
    end
  end

  always_comb begin
    tok_t ta, tb;
    logic va, vb, used;
    ta       = '0;
    tb       = '0;
    va       = 1'b0;
    vb       = 1'b0;
    used     = 1'b0;
    mode_nxt = mode_r;
    held_nxt = held_r;
    wlen_nxt = wlen_r;
    mask_nxt = mask_r;

    unique case (mode_r)
      MODE_WORD: begin
        if (is_word_char(text_byte)) begin
          used = 1'b1;
          if (wlen_r >= MAX_LEN) begin
            mask_nxt = '0;
          end else begin
            mask_nxt = ext_mask;
            wlen_nxt = wlen_r + WLEN_W'(1);
          end
        end else begin
          va = 1'b1;
          ta = word_tok(mask_r, wlen_r);
        end
      end
      MODE_NUM: begin
        if (is_digit(text_byte)) begin
          used = 1'b1;
        end else begin
          va            = 1'b1;
          ta            = '0;
          ta.token_class = CLS_NUMBER;
        end
      end
      MODE_REL: begin
        va = 1'b1;
        if (text_byte == ">" || text_byte == "=") begin
          used = 1'b1;
          ta   = op_tok(CLS_REL_OP, held_r, text_byte);
        end else begin
          ta   = op_tok(CLS_REL_OP, held_r, 8'd0);
        end
      end
      MODE_ARI: begin
        va = 1'b1;
        if (text_byte == "+" || text_byte == "=" || text_byte == "-") begin
          used = 1'b1;
          ta   = op_tok(CLS_ARI_OP, held_r, text_byte);
        end else begin
          ta   = op_tok(CLS_ARI_OP, held_r, 8'd0);
        end
      end
      default: begin
      end
    endcase

    if (!used) begin
      mode_nxt = MODE_IDLE;
      held_nxt = 8'd0;
      wlen_nxt = '0;
      mask_nxt = '1;
      if (is_letter(text_byte) || text_byte == "_") begin
        mode_nxt = MODE_WORD;
        wlen_nxt = WLEN_W'(1);
        mask_nxt = start_mask;
      end else if (is_digit(text_byte)) begin
        mode_nxt = MODE_NUM;
      end else if (text_byte == "<" || text_byte == ">" || text_byte == "=") begin
        mode_nxt = MODE_REL;
        held_nxt = text_byte;
      end else if (text_byte == "+" || text_byte == "-" || text_byte == "*" ||
                   text_byte == "/") begin
        mode_nxt = MODE_ARI;
        held_nxt = text_byte;
      end else if (is_punct(text_byte)) begin
        vb = 1'b1;
        tb = op_tok(CLS_PUNCT, text_byte, 8'd0);
      end
    end else if (mode_r == MODE_REL || mode_r == MODE_ARI) begin
      mode_nxt = MODE_IDLE;
      held_nxt = 8'd0;
    end

    if (end_of_text) begin
      unique case (mode_nxt)
        MODE_WORD: begin
          vb = 1'b1;
          tb = word_tok(mask_nxt, wlen_nxt);
        end
        MODE_NUM: begin
          vb = 1'b1;
          tb = op_tok(CLS_NUMBER, 8'd0, 8'd0);
        end
        MODE_REL: begin
          vb = 1'b1;
          tb = op_tok(CLS_REL_OP, held_nxt, 8'd0);
        end
        MODE_ARI: begin
          vb = 1'b1;
          tb = op_tok(CLS_ARI_OP, held_nxt, 8'd0);
        end
        default: begin
        end
      endcase
      mode_nxt = MODE_IDLE;
      held_nxt = 8'd0;
      wlen_nxt = '0;
      mask_nxt = '1;
    end

    ta.run_last = !vb;
    tb.run_last = 1'b1;
    if (va) begin
      toks.n  = vb ? 2'd2 : 2'd1;
      toks.t0 = ta;
      toks.t1 = tb;
    end else begin
      toks.n  = vb ? 2'd1 : 2'd0;
      toks.t0 = tb;
      toks.t1 = tb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= 8'd0;
      wlen_r <= '0;
      mask_r <= '1;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      wlen_r <= wlen_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ctc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_queue: token queue and result side
// Takes up to two tokens per cycle from the scanner and presents the oldest
// one on the result side, one transaction per cycle.
// ----------------------------------------------------------------------------
module ctc_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire ctc_pkg::tok_pair_t         toks,
  input  wire logic                       pop,
  output ctc_pkg::tok_t                   head,
  output logic                            empty,
  output logic                            full,
  output logic [ctc_pkg::Q_CNT_W-1:0]     level
);
  import ctc_pkg::*;

  tok_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]         n_wr;
  logic               rd;

  assign n_wr  = wr_en ? toks.n : 2'd0;
  assign rd    = pop && (cnt_r != '0);
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r > Q_CNT_W'(Q_DEPTH - 2));
  assign level = cnt_r;
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + Q_PTR_W'(n_wr);
    rptr_nxt = rptr_r + Q_PTR_W'(rd);
    cnt_nxt  = cnt_r + Q_CNT_W'(n_wr) - Q_CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem_r[wptr_r] <= toks.t0;
    end
    if (n_wr == 2'd2) begin
      mem_r[wptr_r + Q_PTR_W'(1)] <= toks.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/c_token_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_token_classifier: byte-serial C token classifier
// A token is queued when the byte that ends it is accepted. Throughput: one byte
// per cycle while not full; results leave one per cycle, up to two per byte.
// Rate is set by the four-entry token queue: push stalls when fewer than two
// entries are free. Reset: synchronous, active low; scanner idle, queue empty.
// ----------------------------------------------------------------------------
module c_token_classifier #(
  parameter int KEYWORD_COUNT   = 34,
  parameter int MAX_WORD_LENGTH = 32,
  parameter int KEYWORD_CHARS   = 11
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      out_token_class,
  output logic [5:0]      out_keyword_index,
  output logic [7:0]      out_first_char,
  output logic [7:0]      out_second_char,
  output logic            out_run_last
);
  import ctc_pkg::*;

  tok_pair_t          toks;
  tok_t               head;
  logic               accept;
  logic [Q_CNT_W-1:0] level;

  assign accept = push && !full;

  ctc_front #(
    .KEYWORD_COUNT  (KEYWORD_COUNT),
    .MAX_WORD_LENGTH(MAX_WORD_LENGTH),
    .KEYWORD_CHARS  (KEYWORD_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .text_byte  (in_text_byte),
    .end_of_text(in_end_of_text),
    .toks       (toks)
  );

  ctc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr_en(accept),
    .toks (toks),
    .pop  (pop),
    .head (head),
    .empty(empty),
    .full (full),
    .level(level)
  );

  assign out_token_class   = head.token_class;
  assign out_keyword_index = head.keyword_index;
  assign out_first_char    = head.first_char;
  assign out_second_char   = head.second_char;
  assign out_run_last      = head.run_last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= Q_CNT_W'(Q_DEPTH))
    else $error("token queue overflow");

  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_run_last) |-> (level >= Q_CNT_W'(2)))
    else $error("first token of a transaction without its partner");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(pop && !empty)) |=> (level >= $past(level)))
    else $error("queue level dropped without a pop");

endmodule
`default_nettype wire
